// ===== rtl/rsi_pkg.sv =====
// Shared constants for the RSI stream block.
// No dependencies; used by rsi_div and rsi_indicator_stream_top.
`default_nettype none

package rsi_pkg;

  localparam int PRICE_W = 32;   // Q16.16 price
  localparam int RSI_W   = 15;   // Q7.8 RSI, also the quotient width of the divider

  // 100.0 in Q7.8
  localparam logic [RSI_W-1:0] RSI_FULL_SCALE = 15'd25600;

endpackage

`default_nettype wire

// ===== rtl/rsi_indicator_stream_top.sv =====
// Streaming RSI (simple average) over the last PERIOD price changes.
// Depends on rsi_pkg and rsi_div.
`default_nettype none

// One price per transfer in Q16.16; series_start_i restarts the history with
// this price. Once PERIOD changes of a series are seen, each price yields one
// RSI value in Q7.8 (25600 = 100.0). Per accepted item: the first price of a
// series is only stored; a warm-up price is compared, then the ring is read
// and updated; a price that yields a result then passes through the 15-step
// restoring divider (one quotient bit per cycle), or bypasses it when the loss
// sum is zero. The gain/loss rings live in one PERIOD-deep memory with a
// single registered read port; unwritten slots are masked by the fill count,
// so no clearing pass is needed after reset or series start.
// A finished result waits in the output register while the next price is
// already taken in.
module rsi_indicator_stream_top #(
  parameter int PERIOD = 14
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [rsi_pkg::PRICE_W-1:0]   price_i,
  input  wire logic                          series_start_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [rsi_pkg::RSI_W-1:0]          rsi_value_o
);

  localparam int PW    = rsi_pkg::PRICE_W;
  localparam int QW    = rsi_pkg::RSI_W;
  localparam int PtrW  = $clog2(PERIOD);
  localparam int SeenW = $clog2(PERIOD + 2);
  localparam int SumW  = PW + $clog2(PERIOD);
  localparam int DenW  = SumW + 1;
  localparam int NumW  = SumW + QW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_PREP,
    ST_DIV,
    ST_DELIVER
  } state_e;

  state_e           state_q;
  logic [PW-1:0]    last_q;
  logic [PW-1:0]    gain_q, loss_q;
  logic [SumW-1:0]  gsum_q, lsum_q;
  logic [PtrW-1:0]  ptr_q;
  logic [PtrW-1:0]  slot_q;
  logic [SeenW-1:0] seen_q;
  logic             full_q;
  logic [QW-1:0]    res_q;
  logic             out_valid_q;
  logic [QW-1:0]    rsi_q;

  // ring memory: {gain, loss} per slot
  logic [2*PW-1:0]  ring [PERIOD];
  logic [2*PW-1:0]  rd_q;
  logic             ring_we;
  logic             ring_re;

  logic             accept;
  logic             deliver;
  logic             price_ge;
  logic [PW-1:0]    up_diff, dn_diff;
  logic [PW-1:0]    old_gain, old_loss;
  logic [SeenW-1:0] seen_inc;
  logic             div_start;
  logic             div_done;
  logic [QW-1:0]    div_quo;
  logic [NumW-1:0]  div_num;
  logic [DenW-1:0]  div_den;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  // result moves into the output register once it is free
  assign deliver = (state_q == ST_DELIVER) && (!out_valid_q || out_ready_i);

  assign price_ge = (price_i >= last_q);
  assign up_diff  = price_i - last_q;
  assign dn_diff  = last_q - price_i;

  // slot content counts only once the ring has wrapped
  assign old_gain = full_q ? rd_q[2*PW-1:PW] : '0;
  assign old_loss = full_q ? rd_q[PW-1:0]    : '0;

  assign seen_inc = (seen_q == SeenW'(PERIOD + 1)) ? seen_q : seen_q + 1'b1;

  assign ring_re = accept;
  assign ring_we = (state_q == ST_UPDATE);

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring[slot_q] <= {gain_q, loss_q};
    end
    if (ring_re) begin
      rd_q <= ring[ptr_q];
    end
  end

  assign div_start = (state_q == ST_PREP) && (lsum_q != '0);
  assign div_num   = NumW'(gsum_q) * NumW'(rsi_pkg::RSI_FULL_SCALE);
  assign div_den   = DenW'(gsum_q) + DenW'(lsum_q);

  rsi_div #(
    .NumW (NumW),
    .DenW (DenW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= '0;
      gain_q      <= '0;
      loss_q      <= '0;
      gsum_q      <= '0;
      lsum_q      <= '0;
      ptr_q       <= '0;
      slot_q      <= '0;
      seen_q      <= '0;
      full_q      <= 1'b0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      rsi_q       <= '0;
    end else begin
      if (deliver) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            last_q <= price_i;
            if (series_start_i || (seen_q == '0)) begin
              // first price of a series: store only
              gsum_q <= '0;
              lsum_q <= '0;
              ptr_q  <= '0;
              seen_q <= SeenW'(1);
            end else begin
              gain_q  <= price_ge ? up_diff : '0;
              loss_q  <= price_ge ? '0 : dn_diff;
              slot_q  <= ptr_q;
              full_q  <= (seen_q == SeenW'(PERIOD + 1));
              state_q <= ST_UPDATE;
            end
          end
        end

        ST_UPDATE: begin
          gsum_q <= gsum_q - SumW'(old_gain) + SumW'(gain_q);
          lsum_q <= lsum_q - SumW'(old_loss) + SumW'(loss_q);
          ptr_q  <= (slot_q == PtrW'(PERIOD - 1)) ? '0 : slot_q + 1'b1;
          seen_q <= seen_inc;
          state_q <= (seen_inc == SeenW'(PERIOD + 1)) ? ST_PREP : ST_IDLE;
        end

        ST_PREP: begin
          if (lsum_q == '0) begin
            res_q   <= rsi_pkg::RSI_FULL_SCALE;
            state_q <= ST_DELIVER;
          end else begin
            state_q <= ST_DIV;
          end
        end

        ST_DIV: begin
          if (div_done) begin
            res_q   <= div_quo;
            state_q <= ST_DELIVER;
          end
        end

        ST_DELIVER: begin
          // wait for the output register to free up
          if (deliver) begin
            rsi_q   <= res_q;
            state_q <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign rsi_value_o = rsi_q;

endmodule

`default_nettype wire

// ===== rtl/rsi_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, RSI_W steps.
// Depends on rsi_pkg. Caller guarantees num_i / den_i < 2**RSI_W and den_i != 0.
`default_nettype none

module rsi_div #(
  parameter int NumW = 51,
  parameter int DenW = 37
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [NumW-1:0]          num_i,
  input  wire logic [DenW-1:0]          den_i,
  output logic                          done_o,
  output logic [rsi_pkg::RSI_W-1:0]     quo_o
);

  localparam int QW   = rsi_pkg::RSI_W;
  localparam int CntW = $clog2(QW + 1);

  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [QW-1:0]   low_q;
  logic [QW-1:0]   quo_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;

  logic [DenW:0]   trial;
  logic [DenW+1:0] diff;
  logic            ge;

  // shift in the next numerator bit, subtract the divisor if it fits
  assign trial = {rem_q, low_q[QW-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};
  assign ge    = ~diff[DenW+1];
  assign rem_d = ge ? diff[DenW-1:0] : trial[DenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // top part of the numerator is already below the divisor
      rem_q <= DenW'(num_i[NumW-1:QW]);
      low_q <= num_i[QW-1:0];
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      low_q <= {low_q[QW-2:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire
